### rtl/tagged_interval_timing_stats_unit_macros.svh
// Assertion macros shared by the tagged interval timing statistics RTL.
`ifndef TAGGED_INTERVAL_TIMING_STATS_UNIT_MACROS_SVH
`define TAGGED_INTERVAL_TIMING_STATS_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TAGSTAT_ASSERT_NOW(label, cond_a, cond_c, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |-> (cond_c)) else $error(msg);

// Next-cycle implication, checked outside reset
`define TAGSTAT_ASSERT_NEXT(label, cond_a, cond_c, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |=> (cond_c)) else $error(msg);

`endif

### rtl/tagstat_pkg.sv
// Shared types and constants for the tagged interval timing statistics unit.
package tagstat_pkg;

    localparam int KEY_IN_W   = 16;
    localparam int TS_W       = 63;
    localparam int DATA_W     = 64;
    localparam int CNT_W      = 32;
    localparam int SLOT_OUT_W = 6;

    // greatest signed 64-bit value, reset value of the minimum pair
    localparam logic signed [DATA_W-1:0] INT_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef enum logic {
        OP_BEGIN = 1'b0,
        OP_END   = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_NEW     = 3'd0,
        ST_RESTART = 3'd1,
        ST_FULL    = 3'd2,
        ST_END_OK  = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    typedef struct packed {
        t_op                 opcode;
        logic [KEY_IN_W-1:0] tag_key;
        logic [TS_W-1:0]     timestamp;
    } t_in_word;

    typedef struct packed {
        t_status                   status;
        logic [SLOT_OUT_W-1:0]     slot;
        logic signed [DATA_W-1:0]  interval;
        logic signed [DATA_W-1:0]  total_time;
        logic [CNT_W-1:0]          call_count;
        logic signed [DATA_W-1:0]  largest;
        logic signed [DATA_W-1:0]  second_largest;
        logic signed [DATA_W-1:0]  smallest;
        logic signed [DATA_W-1:0]  second_smallest;
    } t_out_word;

    // one table entry as held in the statistics RAM
    typedef struct packed {
        logic [TS_W-1:0]           start_time;
        logic signed [DATA_W-1:0]  total;
        logic [CNT_W-1:0]          calls;
        logic signed [DATA_W-1:0]  max0;
        logic signed [DATA_W-1:0]  max1;
        logic signed [DATA_W-1:0]  min0;
        logic signed [DATA_W-1:0]  min1;
    } t_entry;

endpackage

### rtl/tagstat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tagstat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tagstat_queue.sv
// Two-word command queue between the classify front end and the update back end.
module tagstat_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int DEPTH = 2;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [CW-1:0]    r_count;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

### rtl/tagstat_front.sv
// Front end: accepts words, scans the key table and classifies each word.
module tagstat_front #(
    parameter int TAG_SLOTS = 64,
    parameter int KEY_BITS  = 16,
    localparam int IW = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1,
    localparam int CMD_W = $bits(tagstat_pkg::t_status) + IW + tagstat_pkg::TS_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  tagstat_pkg::t_in_word i_word,
    output logic                  o_stall,
    output logic                  o_push,
    output logic [CMD_W-1:0]      o_cmd,
    input  logic                  i_full
);

    import tagstat_pkg::*;

    localparam int KW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int CW = $clog2(TAG_SLOTS + 1);

    typedef enum logic [1:0] {
        F_IDLE,
        F_SCAN,
        F_PUSH
    } t_fstate;

    typedef struct packed {
        t_status         kind;
        logic [IW-1:0]   slot;
        logic [TS_W-1:0] ts;
    } t_cmd;

    t_fstate          r_state;
    t_op              r_op;
    logic [KW-1:0]    r_key;
    logic [TS_W-1:0]  r_ts;
    logic [IW-1:0]    r_idx;
    logic             r_hit;
    logic [CW-1:0]    r_fill;

    logic [KW-1:0]    key_rd;
    logic [IW-1:0]    key_raddr;
    logic             key_we;
    logic             key_match;
    logic             scan_last;
    logic             table_full;
    t_status          kind;
    t_cmd             cmd;

    // key table: one compare per cycle while scanning
    tagstat_ram #(
        .WIDTH (KW),
        .DEPTH (TAG_SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (IW'(r_fill)),
        .i_wdata (r_key),
        .i_re    (1'b1),
        .i_raddr (key_raddr),
        .o_rdata (key_rd)
    );

    // scan address runs one ahead of the entry being compared
    assign key_raddr = (r_state == F_SCAN) ? IW'(r_idx + 1'b1) : '0;
    assign key_match = (key_rd == r_key);
    assign scan_last = (CW'(r_idx) == (r_fill - CW'(1)));
    assign table_full = (r_fill == CW'(TAG_SLOTS));

    // classify the word once the scan is done
    always_comb begin
        if (r_op == OP_BEGIN) begin
            if (r_hit) begin
                kind = ST_RESTART;
            end else if (table_full) begin
                kind = ST_FULL;
            end else begin
                kind = ST_NEW;
            end
        end else begin
            kind = r_hit ? ST_END_OK : ST_UNKNOWN;
        end
    end

    always_comb begin
        cmd.kind = kind;
        cmd.ts   = r_ts;
        if (r_hit) begin
            cmd.slot = r_idx;
        end else if (kind == ST_NEW) begin
            cmd.slot = IW'(r_fill);
        end else begin
            cmd.slot = '0;
        end
    end

    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_cmd   = cmd;
    assign o_stall = (r_state != F_IDLE);
    // new tags take the lowest free slot, which is always the fill count
    assign key_we  = o_push && (kind == ST_NEW);

    // state and word registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_fill  <= '0;
            r_hit   <= 1'b0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_word.opcode;
                        r_key   <= KW'(i_word.tag_key);
                        r_ts    <= i_word.timestamp;
                        r_idx   <= '0;
                        r_hit   <= 1'b0;
                        r_state <= (r_fill == '0) ? F_PUSH : F_SCAN;
                    end
                end
                F_SCAN: begin
                    if (key_match) begin
                        r_hit   <= 1'b1;
                        r_state <= F_PUSH;
                    end else if (scan_last) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_idx <= IW'(r_idx + 1'b1);
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                        if (kind == ST_NEW) begin
                            r_fill <= r_fill + CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/tagstat_back.sv
// Back end: read-modify-write of one table entry and the result register.
module tagstat_back #(
    parameter int TAG_SLOTS = 64,
    localparam int IW = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1,
    localparam int CMD_W = $bits(tagstat_pkg::t_status) + IW + tagstat_pkg::TS_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  logic [CMD_W-1:0]       i_cmd,
    output logic                   o_pop,
    output logic                   o_valid,
    output tagstat_pkg::t_out_word o_word,
    input  logic                   i_stall
);

    import tagstat_pkg::*;

    localparam int EW = $bits(t_entry);

    typedef enum logic [1:0] {
        B_IDLE,
        B_CALC,
        B_UPD
    } t_bstate;

    typedef struct packed {
        t_status         kind;
        logic [IW-1:0]   slot;
        logic [TS_W-1:0] ts;
    } t_cmd;

    t_bstate                  r_state;
    t_cmd                     r_cmd;
    logic signed [DATA_W-1:0] r_ivl;
    logic                     r_o_valid;
    t_out_word                r_word;

    t_cmd                     cmd_in;
    logic [EW-1:0]            ram_rdata;
    t_entry                   rd;
    t_entry                   n_entry;
    t_out_word                n_word;
    logic                     upd_we;
    logic                     out_free;
    logic                     ram_we;

    assign cmd_in = t_cmd'(i_cmd);
    assign rd     = t_entry'(ram_rdata);

    // entry table: start time and statistics in one word
    tagstat_ram #(
        .WIDTH (EW),
        .DEPTH (TAG_SLOTS)
    ) u_stat_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cmd.slot),
        .i_wdata (n_entry),
        .i_re    (o_pop),
        .i_raddr (cmd_in.slot),
        .o_rdata (ram_rdata)
    );

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign out_free = !r_o_valid || !i_stall;
    assign ram_we   = (r_state == B_UPD) && out_free && upd_we;

    // new entry value and result word
    always_comb begin
        n_entry = rd;
        n_word  = '0;
        upd_we  = 1'b0;
        n_word.status = r_cmd.kind;
        unique case (r_cmd.kind)
            ST_NEW: begin
                // freshly claimed slot starts from the reset statistics
                n_entry.start_time = r_cmd.ts;
                n_entry.total      = '0;
                n_entry.calls      = '0;
                n_entry.max0       = '0;
                n_entry.max1       = '0;
                n_entry.min0       = INT_TOP;
                n_entry.min1       = INT_TOP;
                upd_we             = 1'b1;
            end
            ST_RESTART: begin
                n_entry.start_time = r_cmd.ts;
                upd_we             = 1'b1;
            end
            ST_END_OK: begin
                n_entry.total = n_entry.total + r_ivl;
                n_entry.calls = n_entry.calls + CNT_W'(1);
                // top-two maxima
                if ($signed(rd.max0) < r_ivl) begin
                    n_entry.max1 = rd.max0;
                    n_entry.max0 = r_ivl;
                end else if ($signed(rd.max1) < r_ivl) begin
                    n_entry.max1 = r_ivl;
                end
                // top-two minima
                if (r_ivl < $signed(rd.min0)) begin
                    n_entry.min1 = rd.min0;
                    n_entry.min0 = r_ivl;
                end else if (r_ivl < $signed(rd.min1)) begin
                    n_entry.min1 = r_ivl;
                end
                n_word.interval = r_ivl;
                upd_we          = 1'b1;
            end
            default: begin
                // table full or unknown tag: status only, no state change
                upd_we = 1'b0;
            end
        endcase
        if (upd_we) begin
            n_word.slot            = SLOT_OUT_W'(r_cmd.slot);
            n_word.total_time      = n_entry.total;
            n_word.call_count      = n_entry.calls;
            n_word.largest         = n_entry.max0;
            n_word.second_largest  = n_entry.max1;
            n_word.smallest        = n_entry.min0;
            n_word.second_smallest = n_entry.min1;
        end
    end

    // state, interval and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == B_UPD && out_free) begin
                r_o_valid <= 1'b1;
                r_word    <= n_word;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= cmd_in;
                        r_state <= B_CALC;
                    end
                end
                B_CALC: begin
                    r_ivl   <= $signed({1'b0, r_cmd.ts} - {1'b0, rd.start_time});
                    r_state <= B_UPD;
                end
                B_UPD: begin
                    if (out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_o_valid;
    assign o_word  = r_word;

endmodule

### rtl/tagged_interval_timing_stats_unit.sv
// Top level of the tagged interval timing statistics unit.
//
//  Channel | Dir | Handshake        | Word
//  --------+-----+------------------+------------------------
//  events  | in  | i_valid, o_stall | t_in_word  (i_word)
//  results | out | o_valid, i_stall | t_out_word (o_word)
//
// Front end: per word, compares entries in order up to the fill count, stopping
// at a match, one key compare per cycle through the registered key RAM read port.
// Back end: per word, RAM read, interval subtract, then update and write.
// Reset is synchronous, active low; entries are initialized when claimed, so
// there is no clearing pass and the unit takes words right after reset.
// A two-word queue sits between the ends; the result register holds its word
// while i_stall is high and the front keeps accepting until the queue fills.
`include "tagged_interval_timing_stats_unit_macros.svh"

module tagged_interval_timing_stats_unit #(
    parameter int TAG_SLOTS = 64,
    parameter int KEY_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  tagstat_pkg::t_in_word  i_word,
    output logic                   o_stall,
    output logic                   o_valid,
    output tagstat_pkg::t_out_word o_word,
    input  logic                   i_stall
);

    import tagstat_pkg::*;

    localparam int IW    = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
    localparam int CMD_W = $bits(t_status) + IW + TS_W;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [CMD_W-1:0] q_wdata;
    logic [CMD_W-1:0] q_rdata;

    // lookup and classify
    tagstat_front #(
        .TAG_SLOTS (TAG_SLOTS),
        .KEY_BITS  (KEY_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_stall (o_stall),
        .o_push  (q_push),
        .o_cmd   (q_wdata),
        .i_full  (q_full)
    );

    // command queue
    tagstat_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // entry update and results
    tagstat_back #(
        .TAG_SLOTS (TAG_SLOTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cmd   (q_rdata),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .o_word  (o_word),
        .i_stall (i_stall)
    );

    // checks
    `TAGSTAT_ASSERT_NOW(a_no_overflow, q_push, !q_full, "command queue overflow")
    `TAGSTAT_ASSERT_NOW(a_no_underflow, q_pop, !q_empty, "command queue underflow")
    `TAGSTAT_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall,
        "front not busy after accept")
    `TAGSTAT_ASSERT_NOW(a_drop_clean,
        o_valid && (o_word.status == ST_FULL || o_word.status == ST_UNKNOWN),
        o_word.slot == '0 && o_word.interval == '0 && o_word.call_count == '0,
        "dropped word carries entry data")

endmodule
